// File: hw/rtl/rth_pkg.sv
// Shared types and constants for the restaurant table histogram.
package rth_pkg;

	localparam int MAX_TABLE_SIZE_DEF = 256;
	localparam int COUNT_BITS_DEF     = 16;

	typedef enum logic [1:0] {
		ACT_SEAT   = 2'd0,
		ACT_OPEN   = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DRAW  = 2'd1,
		ST_LIMIT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_WALK,
		SQ_RD,
		SQ_CHK,
		SQ_WRA,
		SQ_WRB,
		SQ_DONE
	} seq_state_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic valid;
		logic last;
		logic seat;
	} mac_ctl_t;

	// Verdict of the multiply-accumulate unit for the entry in its compare stage.
	typedef struct packed {
		logic hit;
		logic miss;
	} mac_res_t;

	typedef struct packed {
		logic [8:0]  table_size;
		logic [15:0] customers;
		logic [15:0] tables;
		logic        empty_res;
		status_t     status;
	} res_t;

endpackage

// File: hw/rtl/rth_if.sv
// Handshake channel interfaces for requests, results and the discount register.
interface rth_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] draw;

	modport source (output valid, action, draw, input ready);
	modport sink (input valid, action, draw, output ready);
endinterface

interface rth_result_if;
	logic        valid;
	logic        ready;
	logic [8:0]  table_size;
	logic [15:0] customers;
	logic [15:0] tables;
	logic        empty_res;
	logic [1:0]  status;

	modport source (output valid, table_size, customers, tables, empty_res, status,
		input ready);
	modport sink (input valid, table_size, customers, tables, empty_res, status,
		output ready);
endinterface

interface rth_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] discount;

	modport source (output valid, discount, input ready);
	modport sink (input valid, discount, output ready);
endinterface

// File: hw/rtl/restaurant_table_histogram.sv
// Top level: table-size histogram with seat, open and remove requests.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  item     | in  | valid / ready | action[1:0], draw[31:0]
//  result   | out | valid / ready | table_size[8:0], customers, tables, empty_res,
//           |     |               | status[1:0]
//  cfg      | in  | valid / ready | discount[15:0] (Q0.16), always ready
//
// Seat and remove requests walk the histogram, one read per cycle through the shared
// multiply-accumulate unit, then read the neighbor bucket and write two buckets on the
// single write port; removing from a table of one skips that read and the second write.
// Open requests read, check and write one bucket; failed requests stop after the walk
// or the check. After reset a clearing pass zeroes every histogram entry; item is
// not ready meanwhile. A request may be taken while the previous result waits in the
// output register; a stalled result holds the sequencer at its final step.
module restaurant_table_histogram import rth_pkg::*; #(
	parameter int MAX_TABLE_SIZE = MAX_TABLE_SIZE_DEF,
	parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	rth_item_if.sink     item,
	rth_result_if.source result,
	rth_cfg_if.sink      cfg
);

	localparam int AB = $clog2(MAX_TABLE_SIZE);
	localparam int SB = $clog2(MAX_TABLE_SIZE + 1);

	logic [15:0]           discount_q;
	mac_ctl_t              mac_ctl;
	mac_res_t              mac_res;
	logic [SB-1:0]         mac_size;
	logic [COUNT_BITS-1:0] mac_cnt;
	logic [31:0]           mac_target;
	logic [SB-1:0]         hit_size;
	logic [COUNT_BITS-1:0] hit_cnt;
	logic                  ram_we;
	logic [AB-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic                  ram_re;
	logic [AB-1:0]         ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;
	logic                  out_valid_q;
	res_t                  out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q <= '0;
		end else if (cfg.valid) begin
			discount_q <= cfg.discount;
		end
	end

	rth_seq #(
		.MAX_TABLE_SIZE(MAX_TABLE_SIZE),
		.COUNT_BITS    (COUNT_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item.valid),
		.item_ready(item.ready),
		.action    (item.action),
		.draw      (item.draw),
		.mac_ctl   (mac_ctl),
		.mac_size  (mac_size),
		.mac_cnt   (mac_cnt),
		.mac_target(mac_target),
		.mac_res   (mac_res),
		.hit_size  (hit_size),
		.hit_cnt   (hit_cnt),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	rth_mac #(
		.MAX_TABLE_SIZE(MAX_TABLE_SIZE),
		.COUNT_BITS    (COUNT_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.size    (mac_size),
		.cnt     (mac_cnt),
		.discount(discount_q),
		.target  (mac_target),
		.res     (mac_res),
		.hit_size(hit_size),
		.hit_cnt (hit_cnt)
	);

	rth_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_TABLE_SIZE)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register decouples the result channel from the sequencer.
	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.table_size = out_q.table_size;
	assign result.customers  = out_q.customers;
	assign result.tables     = out_q.tables;
	assign result.empty_res  = out_q.empty_res;
	assign result.status     = out_q.status;

endmodule

// File: hw/rtl/rth_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/rth_mac.sv
// Shared weight multiply, running-sum accumulate and compare unit for the size walk.
module rth_mac import rth_pkg::*; #(
	parameter int MAX_TABLE_SIZE = MAX_TABLE_SIZE_DEF,
	parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mac_ctl_t                             ctl,
	input  logic [$clog2(MAX_TABLE_SIZE+1)-1:0] size,
	input  logic [COUNT_BITS-1:0]               cnt,
	input  logic [15:0]                         discount,
	input  logic [31:0]                         target,
	output mac_res_t                            res,
	output logic [$clog2(MAX_TABLE_SIZE+1)-1:0] hit_size,
	output logic [COUNT_BITS-1:0]               hit_cnt
);

	localparam int SB = $clog2(MAX_TABLE_SIZE + 1);
	localparam int WB = SB + 16;
	localparam int CB = (COUNT_BITS > 32) ? 32 : COUNT_BITS;
	localparam int PW = CB + WB;
	localparam int SW = ((PW > 32) ? PW : 32) + 1;

	logic [WB-1:0]            weight;
	logic [COUNT_BITS+31:0]   cnt_w;
	logic                     cnt_sat;
	logic [CB-1:0]            cnt_c;
	logic [PW-1:0]            prod;
	logic                     valid_s1;
	logic                     last_s1;
	logic                     nz_s1;
	logic [PW-1:0]            prod_s1;
	logic [SB-1:0]            size_s1;
	logic [COUNT_BITS-1:0]    cnt_s1;
	logic [31:0]              cum_q;
	logic [SW-1:0]            sum;
	logic                     reach;

	// Once the count alone passes 32 bits the product is already beyond any draw,
	// since every weight is at least one.
	always_comb begin
		cnt_w   = (COUNT_BITS + 32)'(cnt);
		cnt_sat = (cnt_w >> CB) != '0;
		cnt_c   = cnt_sat ? '1 : cnt_w[CB-1:0];
		if (ctl.seat) begin
			weight = {size, 16'b0} - WB'(discount);
		end else begin
			weight = WB'(size);
		end
		prod = PW'(cnt_c) * PW'(weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.start ? 1'b0 : ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= ctl.last;
		nz_s1   <= cnt != '0;
		prod_s1 <= prod;
		size_s1 <= size;
		cnt_s1  <= cnt;
		if (ctl.start) begin
			cum_q <= '0;
		end else if (valid_s1) begin
			cum_q <= sum[31:0];
		end
	end

	// While the walk goes on the running sum stays below the draw, so 32 bits hold it.
	assign sum      = SW'(cum_q) + SW'(prod_s1);
	assign reach    = sum >= SW'(target);
	assign res.hit  = valid_s1 && nz_s1 && reach;
	assign res.miss = valid_s1 && last_s1 && !(nz_s1 && reach);
	assign hit_size = size_s1;
	assign hit_cnt  = cnt_s1;

	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> !res.hit && !res.miss)
		else $error("walk verdict right after a new request started");

	a_one_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |-> !res.miss)
		else $error("walk reports hit and miss together");

endmodule

// File: hw/rtl/rth_seq.sv
// Sequencer: clearing pass, histogram walk, neighbor read, bucket updates and totals.
module rth_seq import rth_pkg::*; #(
	parameter int MAX_TABLE_SIZE = MAX_TABLE_SIZE_DEF,
	parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic [1:0]                           action,
	input  logic [31:0]                          draw,
	output mac_ctl_t                             mac_ctl,
	output logic [$clog2(MAX_TABLE_SIZE+1)-1:0] mac_size,
	output logic [COUNT_BITS-1:0]               mac_cnt,
	output logic [31:0]                          mac_target,
	input  mac_res_t                             mac_res,
	input  logic [$clog2(MAX_TABLE_SIZE+1)-1:0] hit_size,
	input  logic [COUNT_BITS-1:0]               hit_cnt,
	output logic                                 ram_we,
	output logic [$clog2(MAX_TABLE_SIZE)-1:0]   ram_waddr,
	output logic [COUNT_BITS-1:0]               ram_wdata,
	output logic                                 ram_re,
	output logic [$clog2(MAX_TABLE_SIZE)-1:0]   ram_raddr,
	input  logic [COUNT_BITS-1:0]               ram_rdata,
	output logic                                 res_valid,
	output res_t                                 res,
	input  logic                                 res_ready
);

	localparam int AB = $clog2(MAX_TABLE_SIZE);
	localparam int SB = $clog2(MAX_TABLE_SIZE + 1);
	localparam int CW = AB + 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	seq_state_t            state_q;
	seq_state_t            state_d;
	logic [1:0]            act_q;
	logic [31:0]           target_q;
	logic [CW-1:0]         addr_q;
	logic [SB-1:0]         size_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] nbr_q;
	logic [AB-1:0]         nbr_addr_q;
	logic [COUNT_BITS-1:0] cust_q;
	logic [COUNT_BITS-1:0] tabl_q;
	logic [SB-1:0]         res_size_q;
	status_t               res_status_q;
	logic                  rd_vld_s1;
	logic                  rd_last_s1;
	logic [SB-1:0]         rd_size_s1;
	logic                  accept;
	logic                  issuing;
	logic                  hit_at_max;
	logic                  hit_one;
	logic                  one_q;
	logic                  cust_full;
	logic                  tabl_full;
	logic                  rd_full;
	logic                  seat_limit;
	logic                  open_limit;
	logic [SB+8:0]         size_ext;
	logic [COUNT_BITS+15:0] cust_ext;
	logic [COUNT_BITS+15:0] tabl_ext;

	assign accept     = item_valid && item_ready;
	assign issuing    = (state_q == SQ_WALK) && (addr_q < CW'(MAX_TABLE_SIZE));
	assign hit_at_max = hit_size == SB'(MAX_TABLE_SIZE);
	assign hit_one    = hit_size == SB'(1);
	assign one_q      = size_q == SB'(1);
	assign cust_full  = cust_q == CMAX;
	assign tabl_full  = tabl_q == CMAX;
	assign rd_full    = ram_rdata == CMAX;
	assign seat_limit = hit_at_max || cust_full;
	assign open_limit = cust_full || tabl_full || rd_full;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_CLEAR: begin
				if (addr_q == CW'(MAX_TABLE_SIZE - 1)) begin
					state_d = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				if (accept) begin
					case (action)
						ACT_SEAT, ACT_REMOVE: state_d = SQ_WALK;
						ACT_OPEN:             state_d = SQ_RD;
						default:              state_d = SQ_DONE;
					endcase
				end
			end
			SQ_WALK: begin
				if (mac_res.hit) begin
					if (act_q == ACT_SEAT) begin
						state_d = seat_limit ? SQ_DONE : SQ_RD;
					end else begin
						state_d = hit_one ? SQ_WRA : SQ_RD;
					end
				end else if (mac_res.miss) begin
					state_d = SQ_DONE;
				end
			end
			SQ_RD: state_d = SQ_CHK;
			SQ_CHK: begin
				case (act_q)
					ACT_SEAT:   state_d = rd_full ? SQ_DONE : SQ_WRA;
					ACT_OPEN:   state_d = open_limit ? SQ_DONE : SQ_WRB;
					ACT_REMOVE: state_d = SQ_WRA;
					default:    state_d = SQ_DONE;
				endcase
			end
			SQ_WRA: state_d = SQ_WRB;
			SQ_WRB: state_d = SQ_DONE;
			SQ_DONE: begin
				if (res_ready) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// Memory and unit controls.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			SQ_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q[AB-1:0];
			end
			SQ_WALK: begin
				ram_re    = issuing;
				ram_raddr = addr_q[AB-1:0];
			end
			SQ_RD: begin
				ram_re    = 1'b1;
				ram_raddr = nbr_addr_q;
			end
			SQ_WRA: begin
				ram_we    = 1'b1;
				ram_waddr = AB'(size_q - SB'(1));
				ram_wdata = cnt_q - COUNT_BITS'(1);
			end
			SQ_WRB: begin
				// Closing a table of one leaves no smaller bucket to grow.
				ram_we    = !((act_q == ACT_REMOVE) && one_q);
				ram_waddr = nbr_addr_q;
				ram_wdata = nbr_q + COUNT_BITS'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign item_ready    = state_q == SQ_IDLE;
	assign res_valid     = state_q == SQ_DONE;
	assign mac_ctl.start = accept;
	assign mac_ctl.valid = rd_vld_s1 && (state_q == SQ_WALK);
	assign mac_ctl.last  = rd_last_s1;
	assign mac_ctl.seat  = act_q == ACT_SEAT;
	assign mac_size      = rd_size_s1;
	assign mac_cnt       = ram_rdata;
	assign mac_target    = target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SQ_CLEAR;
			addr_q    <= '0;
			cust_q    <= '0;
			tabl_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issuing;
			if (state_q == SQ_CLEAR || issuing) begin
				addr_q <= addr_q + CW'(1);
			end else if (accept) begin
				addr_q <= '0;
			end
			if (state_q == SQ_WRB) begin
				case (act_q)
					ACT_SEAT: cust_q <= cust_q + COUNT_BITS'(1);
					ACT_OPEN: begin
						cust_q <= cust_q + COUNT_BITS'(1);
						tabl_q <= tabl_q + COUNT_BITS'(1);
					end
					ACT_REMOVE: begin
						if (cust_q != '0) begin
							cust_q <= cust_q - COUNT_BITS'(1);
						end
						if (one_q && tabl_q != '0) begin
							tabl_q <= tabl_q - COUNT_BITS'(1);
						end
					end
					default: cust_q <= cust_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_last_s1 <= addr_q == CW'(MAX_TABLE_SIZE - 1);
		rd_size_s1 <= SB'(addr_q + CW'(1));
		case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					act_q      <= action;
					target_q   <= (action == ACT_REMOVE) ? {16'b0, draw[31:16]} : draw;
					nbr_addr_q <= '0;
					res_size_q <= '0;
					res_status_q <= ST_DRAW;
				end
			end
			SQ_WALK: begin
				if (mac_res.hit) begin
					size_q <= hit_size;
					cnt_q  <= hit_cnt;
					if (act_q == ACT_SEAT) begin
						nbr_addr_q <= AB'(hit_size);
						res_status_q <= ST_LIMIT;
					end else begin
						nbr_addr_q <= AB'(hit_size - SB'(2));
					end
				end
			end
			SQ_CHK: begin
				nbr_q        <= ram_rdata;
				res_status_q <= ST_LIMIT;
			end
			SQ_WRB: begin
				res_status_q <= ST_OK;
				case (act_q)
					ACT_SEAT:   res_size_q <= size_q + SB'(1);
					ACT_OPEN:   res_size_q <= SB'(1);
					ACT_REMOVE: res_size_q <= size_q - SB'(1);
					default:    res_size_q <= '0;
				endcase
			end
			default: begin
				res_size_q <= res_size_q;
			end
		endcase
	end

	assign size_ext       = (SB + 9)'(res_size_q);
	assign cust_ext       = (COUNT_BITS + 16)'(cust_q);
	assign tabl_ext       = (COUNT_BITS + 16)'(tabl_q);
	assign res.table_size = size_ext[8:0];
	assign res.customers  = cust_ext[15:0];
	assign res.tables     = tabl_ext[15:0];
	assign res.empty_res  = cust_q == '0;
	assign res.status     = res_status_q;

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("finished result changed before it was taken");

	a_totals_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SQ_WRB) |=> $stable(cust_q) && $stable(tabl_q))
		else $error("totals changed outside the commit step");

	a_walk_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_WALK || state_q == SQ_RD || state_q == SQ_IDLE) |-> !ram_we)
		else $error("histogram written while it is being searched");

endmodule
